// ----- rtl/tams_pkg.sv -----
// Shared types and constants of the touch ADC trimmed-mean scaler.
// Used by the serial divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tams_pkg;

  // Samples per group and the widths of the sample and drain counters.
  localparam int GROUP_SIZE = 5;
  localparam int CNT_W      = $clog2(GROUP_SIZE);
  localparam int DRAIN_W    = $clog2(GROUP_SIZE - 1);

  // Register and coordinate widths fixed by the register map.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;
  localparam int COORD_W   = 12;
  localparam int GAIN_W    = 8;

  // Serial divider: dividend holds (high - mean) * gain.
  localparam int DIV_W   = COORD_W + GAIN_W;
  localparam int DCNT_W  = $clog2(DIV_W);

  localparam logic [COORD_W-1:0] COORD_MAX = '1;
  // The middle three samples are averaged.
  localparam int                 MEAN_DIV  = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_X_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_DIV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Y_DIV   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFF     = 3'd7;

  // Register reset values.
  localparam logic [CFG_W-1:0]  X_LOW_RST  = 12'd250;
  localparam logic [CFG_W-1:0]  Y_LOW_RST  = 12'd300;
  localparam logic [CFG_W-1:0]  HIGH_RST   = 12'd3800;
  localparam logic [GAIN_W-1:0] X_GAIN_RST = 8'd40;
  localparam logic [CFG_W-1:0]  X_DIV_RST  = 12'd355;
  localparam logic [GAIN_W-1:0] Y_GAIN_RST = 8'd24;
  localparam logic [CFG_W-1:0]  Y_DIV_RST  = 12'd350;
  localparam logic [CFG_W-1:0]  OFF_RST    = 12'd800;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_DRAIN,
    ST_MEAN,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/touch_adc_trimmed_mean_scaler.sv -----
// Top level: five-sample trimmed mean of touch ADC beats, limit check and coordinate scaling.
// Depends on tams_pkg, tams_cell and tams_div.
//
//   port group   dir  fields (lowest bit first)
//   s_*          in   tdata: sample; tuser: axis
//   m_*          out  tdata: filtered, coordinate; tuser: axis_out, in_range
//   cfg_*        in   register write: index, data
//
// Sample beats enter one per cycle, while the input is open, into a chain of five sort cells.
// After the fifth beat the input stalls while the chain settles, the reciprocal multiply
// divides the middle sum by three, the 20-step serial divider for the scale is started
// and run, and the result is loaded. The result sits in an output register; the next
// group fills while it waits, and only the load stalls if it is still held.
// Reset is synchronous and restores the register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module touch_adc_trimmed_mean_scaler
  import tams_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [((ADC_BITS+7)/8)*8-1:0]    s_tdata,   // sample
  input  wire logic                             s_tuser,   // axis
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [2*COORD_W-1:0]                  m_tdata,   // filtered, coordinate
  output logic [1:0]                            m_tuser,   // axis_out, in_range
  input  wire logic                             cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]             cfg_index,
  input  wire logic [CFG_W-1:0]                 cfg_data
);

  localparam int SUM_W = ADC_BITS + 2;
  localparam int CMP_W = (ADC_BITS > COORD_W) ? ADC_BITS : COORD_W;
  // Division by three as a multiply by the rounded-up reciprocal; one spare bit of
  // shift keeps the result exact over the whole range of the sum.
  localparam int               RECIP_SH = SUM_W + 1;
  localparam logic [SUM_W-1:0] RECIP_3  =
    SUM_W'(((64'd1 << RECIP_SH) + MEAN_DIV - 1) / MEAN_DIV);

  // Configuration registers.
  logic [CFG_W-1:0]  x_low_limit, y_low_limit, high_limit;
  logic [GAIN_W-1:0] x_gain, y_gain;
  logic [CFG_W-1:0]  x_divisor, y_divisor, off_screen_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low_limit     <= X_LOW_RST;
      y_low_limit     <= Y_LOW_RST;
      high_limit      <= HIGH_RST;
      x_gain          <= X_GAIN_RST;
      x_divisor       <= X_DIV_RST;
      y_gain          <= Y_GAIN_RST;
      y_divisor       <= Y_DIV_RST;
      off_screen_code <= OFF_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_X_LOW:  x_low_limit     <= cfg_data;
        REG_Y_LOW:  y_low_limit     <= cfg_data;
        REG_HIGH:   high_limit      <= cfg_data;
        REG_X_GAIN: x_gain          <= cfg_data[GAIN_W-1:0];
        REG_X_DIV:  x_divisor       <= cfg_data;
        REG_Y_GAIN: y_gain          <= cfg_data[GAIN_W-1:0];
        REG_Y_DIV:  y_divisor       <= cfg_data;
        REG_OFF:    off_screen_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state.
  state_t             state, state_next;
  logic [CNT_W-1:0]   sample_count;
  logic [DRAIN_W-1:0] drain_count;
  logic               group_axis;
  logic               s_accept;
  logic               last_sample;

  // Datapath.
  logic                 cell_clr;
  logic                 link_valid [GROUP_SIZE+1];
  logic [ADC_BITS-1:0]  link_value [GROUP_SIZE+1];
  logic [ADC_BITS-1:0]  cell_val   [GROUP_SIZE];
  logic [SUM_W-1:0]     mid_sum;
  logic [2*SUM_W-1:0]   mean_prod;
  logic [ADC_BITS-1:0]  mean;
  logic [CMP_W-1:0]     mean_w;
  logic [CFG_W-1:0]     low_sel, div_sel;
  logic [GAIN_W-1:0]    gain_sel;
  logic                 in_range;
  logic [COORD_W-1:0]   diff;
  logic [DIV_W-1:0]     product;
  logic [COORD_W-1:0]   coord;

  logic                 div_start;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quot;
  logic                 load_out;

  assign s_accept    = s_tvalid && s_tready;
  assign last_sample = sample_count == CNT_W'(GROUP_SIZE - 1);

  assign link_valid[0] = s_accept;
  assign link_value[0] = s_tdata[ADC_BITS-1:0];

  for (genvar i = 0; i < GROUP_SIZE; i++) begin : g_cell
    tams_cell #(.W(ADC_BITS)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clr       (cell_clr),
      .in_valid  (link_valid[i]),
      .in_value  (link_value[i]),
      .out_valid (link_valid[i+1]),
      .out_value (link_value[i+1]),
      .held      (cell_val[i])
    );
  end

  // Cells hold the group in ascending order; the middle three are kept.
  assign mid_sum = SUM_W'(cell_val[1]) + SUM_W'(cell_val[2]) + SUM_W'(cell_val[3]);
  assign mean_prod = (2*SUM_W)'(mid_sum) * (2*SUM_W)'(RECIP_3);

  always_comb begin
    if (group_axis) begin
      low_sel  = y_low_limit;
      gain_sel = y_gain;
      div_sel  = y_divisor;
    end else begin
      low_sel  = x_low_limit;
      gain_sel = x_gain;
      div_sel  = x_divisor;
    end
  end

  assign mean_w   = CMP_W'(mean);
  assign in_range = (mean_w >= CMP_W'(low_sel)) && (mean_w <= CMP_W'(high_limit));
  assign diff     = high_limit - mean_w[COORD_W-1:0];
  assign product  = DIV_W'(diff) * DIV_W'(gain_sel);

  always_comb begin
    if (!in_range) begin
      coord = off_screen_code;
    end else if (div_sel == '0) begin
      coord = COORD_MAX;
    end else if (|div_quot[DIV_W-1:COORD_W]) begin
      coord = COORD_MAX;
    end else begin
      coord = div_quot[COORD_W-1:0];
    end
  end

  tams_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (div_sel),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL:       if (s_accept && last_sample) state_next = ST_DRAIN;
      ST_DRAIN:      if (drain_count == DRAIN_W'(GROUP_SIZE - 2)) state_next = ST_MEAN;
      ST_MEAN:       state_next = ST_SCALE_GO;
      ST_SCALE_GO:   state_next = ST_SCALE_WAIT;
      ST_SCALE_WAIT: if (div_done) state_next = ST_DONE;
      ST_DONE:       if (!m_tvalid || m_tready) state_next = ST_FILL;
      default:       state_next = ST_FILL;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    s_tready  = 1'b0;
    cell_clr  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_FILL: begin
        s_tready = 1'b1;
        cell_clr = s_tvalid && (sample_count == '0);
      end
      ST_SCALE_GO: begin
        div_start = 1'b1;
      end
      ST_DONE: begin
        load_out = !m_tvalid || m_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      sample_count <= '0;
      drain_count  <= '0;
      group_axis   <= 1'b0;
    end else begin
      state <= state_next;
      if (s_accept) begin
        if (sample_count == '0) begin
          group_axis <= s_tuser;
        end
        sample_count <= last_sample ? '0 : sample_count + 1'b1;
      end
      if (state == ST_DRAIN) begin
        drain_count <= drain_count + 1'b1;
      end else begin
        drain_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MEAN) begin
      mean <= mean_prod[RECIP_SH +: ADC_BITS];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {coord, mean_w[COORD_W-1:0]};
      m_tuser <= {in_range, group_axis};
    end
  end

`ifndef SYNTHESIS
  // The chain must hold the group in ascending order once it has settled.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_MEAN |-> (cell_val[0] <= cell_val[1] && cell_val[1] <= cell_val[2] &&
                          cell_val[2] <= cell_val[3] && cell_val[3] <= cell_val[4]))
    else $error("sort chain out of order");

  // Five values never overflow the last cell.
  assert property (@(posedge clk) disable iff (rst) !link_valid[GROUP_SIZE])
    else $error("value pushed out of the sort chain");

  // The fifth beat of a group closes the input until the result is loaded.
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && last_sample) |=> !s_tready)
    else $error("input open after the last beat of a group");

  // The divider only finishes while the controller waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_SCALE_WAIT)
    else $error("divider result arrived unexpectedly");
`endif

endmodule

`default_nettype wire

// ----- rtl/tams_cell.sv -----
// One cell of the insertion sort chain: keeps the smaller value, passes the larger on.
// Standalone; chained by the top level.
`timescale 1ns / 1ps
`default_nettype none

module tams_cell #(
  parameter int W = 12
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         clr,
  input  wire logic         in_valid,
  input  wire logic [W-1:0] in_value,
  output logic              out_valid,
  output logic [W-1:0]      out_value,
  output logic [W-1:0]      held
);

  logic full;
  logic keep_in;

  assign keep_in = in_value < held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full      <= 1'b0;
      out_valid <= 1'b0;
    end else if (clr) begin
      // A new group starts: earlier contents count as empty.
      full      <= in_valid;
      out_valid <= 1'b0;
      if (in_valid) begin
        held <= in_value;
      end
    end else if (in_valid) begin
      if (!full) begin
        full      <= 1'b1;
        held      <= in_value;
        out_valid <= 1'b0;
      end else begin
        held      <= keep_in ? in_value : held;
        out_value <= keep_in ? held : in_value;
        out_valid <= 1'b1;
      end
    end else begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tams_div.sv -----
// Restoring divider, one quotient bit per cycle, for the coordinate scale.
// Depends on tams_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module tams_div
  import tams_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIV_W-1:0]   dividend,
  input  wire logic [COORD_W-1:0] divisor,
  output logic                    done,
  output logic [DIV_W-1:0]        quotient
);

  logic                 busy;
  logic [DCNT_W-1:0]    cnt;
  logic [DIV_W-1:0]     dvd;
  logic [COORD_W-1:0]   rem;
  logic [COORD_W-1:0]   dsr;
  logic [COORD_W:0]     trial;
  logic                 qbit;
  logic [COORD_W-1:0]   rem_next;

  always_comb begin
    trial = {rem, dvd[DIV_W-1]};
    qbit  = trial >= {1'b0, dsr};
    if (qbit) begin
      rem_next = COORD_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[COORD_W-1:0];
    end
  end

  // Quotient bits shift into the dividend register from the bottom.
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[DIV_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- dv/touch_adc_trimmed_mean_scaler_tb.sv -----
// Self-checking testbench for touch_adc_trimmed_mean_scaler: drives sample beats and
// register writes, predicts each group's filtered mean and coordinate, checks result beats.
// Depends on tams_pkg and the RTL of the top level.
`timescale 1ns / 1ps

module touch_adc_trimmed_mean_scaler_tb;
  import tams_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int GROUPS_PER_SETTING = 19;

  typedef struct packed {
    logic              axis;
    logic [11:0]       filtered;
    logic [COORD_W-1:0] coord;
    logic              in_range;
  } touch_point_t;

  class touch_point_scoreboard;
    logic [11:0]       x_low, y_low, high, off_code, x_div, y_div;
    logic [GAIN_W-1:0] x_gain, y_gain;
    logic [11:0]       group_samples [GROUP_SIZE];
    int                group_fill;
    logic              group_axis;
    touch_point_t      pending_points [$];
    int                errors;

    function new();
      x_low = X_LOW_RST;
      y_low = Y_LOW_RST;
      high = HIGH_RST;
      x_gain = X_GAIN_RST;
      x_div = X_DIV_RST;
      y_gain = Y_GAIN_RST;
      y_div = Y_DIV_RST;
      off_code = OFF_RST;
      group_fill = 0;
      group_axis = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_X_LOW:  x_low = data;
        REG_Y_LOW:  y_low = data;
        REG_HIGH:   high = data;
        REG_X_GAIN: x_gain = data[GAIN_W-1:0];
        REG_X_DIV:  x_div = data;
        REG_Y_GAIN: y_gain = data[GAIN_W-1:0];
        REG_Y_DIV:  y_div = data;
        REG_OFF:    off_code = data;
        default: ;
      endcase
    endfunction

    // Sorts the group, averages the middle three and scales against the axis limits.
    function touch_point_t trimmed_mean_point();
      touch_point_t      pt;
      int unsigned       v [GROUP_SIZE];
      int unsigned       t, mean, low, gain, div, scaled;
      for (int i = 0; i < GROUP_SIZE; i++) v[i] = group_samples[i];
      for (int a = 0; a < GROUP_SIZE - 1; a++)
        for (int b = 0; b < GROUP_SIZE - 1 - a; b++)
          if (v[b] > v[b+1]) begin
            t = v[b];
            v[b] = v[b+1];
            v[b+1] = t;
          end
      mean = (v[1] + v[2] + v[3]) / 3;
      low = group_axis ? y_low : x_low;
      gain = group_axis ? y_gain : x_gain;
      div = group_axis ? y_div : x_div;
      pt.axis = group_axis;
      pt.filtered = mean[11:0];
      pt.in_range = (mean >= low) && (mean <= high);
      if (!pt.in_range) begin
        pt.coord = off_code;
      end else if (div == 0) begin
        pt.coord = COORD_MAX;
      end else begin
        scaled = ((high - mean) * gain) / div;
        pt.coord = (scaled > COORD_MAX) ? COORD_MAX : scaled[COORD_W-1:0];
      end
      return pt;
    endfunction

    function void note_sample(logic [11:0] sample, logic axis);
      if (group_fill == 0) group_axis = axis;
      group_samples[group_fill] = sample;
      group_fill++;
      if (group_fill == GROUP_SIZE) begin
        group_fill = 0;
        pending_points.push_back(trimmed_mean_point());
      end
    endfunction

    function void check_point(logic [2*COORD_W-1:0] tdata, logic [1:0] tuser);
      touch_point_t want, got;
      got.axis = tuser[0];
      got.in_range = tuser[1];
      got.filtered = tdata[11:0];
      got.coord = tdata[2*COORD_W-1:COORD_W];
      if (pending_points.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: axis %0d filtered %0d coord %0d in_range %0d",
                   got.axis, got.filtered, got.coord, got.in_range);
        return;
      end
      want = pending_points.pop_front();
      if (got.axis !== want.axis || got.filtered !== want.filtered ||
          got.coord !== want.coord || got.in_range !== want.in_range) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected axis %0d filtered %0d coord %0d in_range %0d, %s",
                   want.axis, want.filtered, want.coord, want.in_range,
                   $sformatf("got axis %0d filtered %0d coord %0d in_range %0d",
                             got.axis, got.filtered, got.coord, got.in_range));
      end
    endfunction

    function int pending();
      return pending_points.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;   // sample
  logic                   s_tuser = 1'b0; // axis
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [2*COORD_W-1:0]   m_tdata;        // filtered, coordinate
  logic [1:0]             m_tuser;        // axis_out, in_range
  logic                   cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_X_LOW;
  logic [CFG_W-1:0]       cfg_data = '0;

  touch_point_scoreboard  sb = new();
  bit                     no_gaps = 1'b0;
  int                     hold_request = 0;
  int                     idle_cycles = 0;

  touch_adc_trimmed_mean_scaler u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_sample(logic [11:0] sample, logic axis);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'($urandom), sample};
    s_tuser <= axis;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(sample, axis);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
  endtask

  // Gains take 12-bit data so the unused upper bits get exercised too.
  task automatic apply_setting(logic [11:0] x_low, logic [11:0] y_low, logic [11:0] high,
                               logic [11:0] x_gain, logic [11:0] x_div,
                               logic [11:0] y_gain, logic [11:0] y_div, logic [11:0] off);
    write_reg(REG_X_LOW, x_low);
    write_reg(REG_Y_LOW, y_low);
    write_reg(REG_HIGH, high);
    write_reg(REG_X_GAIN, x_gain);
    write_reg(REG_X_DIV, x_div);
    write_reg(REG_Y_GAIN, y_gain);
    write_reg(REG_Y_DIV, y_div);
    write_reg(REG_OFF, off);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Every group is complete here, so once the last result is out the block is idle.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_group(logic [11:0] s0, logic [11:0] s1, logic [11:0] s2,
                            logic [11:0] s3, logic [11:0] s4, logic first_axis);
    send_sample(s0, first_axis);
    send_sample(s1, 1'($urandom));
    send_sample(s2, 1'($urandom));
    send_sample(s3, 1'($urandom));
    send_sample(s4, 1'($urandom));
  endtask

  task automatic send_random_group();
    logic [11:0] s [GROUP_SIZE];
    int          kind, center, value;
    kind = $urandom_range(0, 9);
    center = $urandom_range(0, 4095);
    for (int i = 0; i < GROUP_SIZE; i++) begin
      case (kind)
        0, 1: value = $urandom_range(0, 4095);
        8: value = $urandom_range(0, 1) ? 4095 : 0;
        9: value = center;
        default: value = center + $urandom_range(0, 80) - 40;
      endcase
      // An occasional wild sample inside a clean group is what the trimming removes.
      if (kind >= 2 && kind <= 7 && $urandom_range(0, 3) == 0) value = $urandom_range(0, 4095);
      if (value < 0) value = 0;
      if (value > 4095) value = 4095;
      s[i] = value[11:0];
    end
    send_group(s[0], s[1], s[2], s[3], s[4], 1'($urandom));
  endtask

  // Result side: random stalls per beat, with one long hold-off when requested.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = draw_gap();
      end
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_point(m_tdata, m_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("touch_adc_trimmed_mean_scaler_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed groups under the reset settings.
    send_group(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2048, 1'b0);
    send_group(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
    send_group(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    send_group(12'd1000, 12'd1010, 12'd990, 12'd5, 12'd4000, 1'b0);
    send_group(12'd2000, 12'd3000, 12'd300, 12'd301, 12'd299, 1'b1);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_setting(X_LOW_RST, Y_LOW_RST, HIGH_RST, X_GAIN_RST, X_DIV_RST,
                         Y_GAIN_RST, Y_DIV_RST, OFF_RST);
        1: apply_setting(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                         12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        // Low limits above the high limit: nothing can be in range.
        2: apply_setting(12'($urandom_range(2000, 4095)), 12'($urandom_range(2000, 4095)),
                         12'($urandom_range(0, 1999)), 12'($urandom), 12'($urandom),
                         12'($urandom), 12'($urandom), 12'($urandom));
        3: apply_setting(12'($urandom_range(0, 1000)), 12'($urandom_range(0, 1000)),
                         12'($urandom_range(3000, 4095)), 12'($urandom), 12'd0,
                         12'($urandom), 12'd0, 12'($urandom));
        4: apply_setting(12'($urandom_range(0, 1000)), 12'($urandom_range(0, 1000)),
                         12'($urandom_range(3000, 4095)), {4'($urandom), 8'd0},
                         12'($urandom_range(1, 4095)), {4'($urandom), 8'd0},
                         12'($urandom_range(1, 4095)), 12'($urandom));
        5: apply_setting(12'd0, 12'd0, 12'd4095, 12'hFFF, 12'd1, 12'hFFF, 12'd1, 12'hFFF);
        6: apply_setting(12'hFFF, 12'hFFF, 12'hFFF, 12'd1, 12'hFFF, 12'd1, 12'hFFF, 12'd0);
        default: apply_setting(12'($urandom_range(0, 1000)), 12'($urandom_range(0, 1000)),
                               12'($urandom_range(3000, 4095)), 12'($urandom_range(1, 255)),
                               12'($urandom_range(1, 4095)), 12'($urandom_range(1, 255)),
                               12'($urandom_range(1, 4095)), 12'($urandom));
      endcase
      if (phase == 1) hold_request = HOLD_CYCLES;
      for (int g = 0; g < GROUPS_PER_SETTING; g++) begin
        no_gaps = (phase == 5) || ($urandom_range(0, 5) == 0);
        send_random_group();
      end
      no_gaps = 1'b0;
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("touch_adc_trimmed_mean_scaler_tb passed");
    end else begin
      $display("touch_adc_trimmed_mean_scaler_tb failed");
    end
    $finish;
  end

endmodule
